### sv/tpm_pkg.sv
// Package: shared types and constants of the task page map bus decoder.
package tpm_pkg;

    localparam int LOCAL_RAM_BYTES = 1024;
    localparam int FPU_BYTES       = 1024;
    localparam int MAP_BYTES       = 512;
    localparam int LRAM_AW         = $clog2(LOCAL_RAM_BYTES);
    localparam int DRAM_DEPTH      = LOCAL_RAM_BYTES + FPU_BYTES;
    localparam int DRAM_AW         = $clog2(DRAM_DEPTH);
    localparam int MAP_AW          = $clog2(MAP_BYTES);

    localparam logic [7:0]  SWITCH_RESET  = 8'd20;
    localparam logic [15:0] TASK_REG_ADDR = 16'h0402;

    typedef enum logic [1:0] {
        KIND_EXT   = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_ROM   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SWITCH   = 2'd0,
        CFG_KEYBOARD = 2'd1,
        CFG_TRAP_ADR = 2'd2,
        CFG_TRAP_STS = 2'd3
    } t_cfg_index;

    // board register offsets within the 0x400 window
    localparam logic [8:0] BREG_TRAP_ADR = 9'h000;
    localparam logic [8:0] BREG_KEYBOARD = 9'h001;
    localparam logic [8:0] BREG_SWITCH   = 9'h002;
    localparam logic [8:0] BREG_TRAP_STS = 9'h003;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

endpackage

### sv/tpm_in_if.sv
// Interface: bus access channel into the decoder.
interface tpm_in_if;
    logic        valid;
    logic        ready;
    logic        is_write;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [15:0] program_counter;

    modport source(output valid, is_write, cpu_address, write_data, program_counter,
                   input ready);
    modport sink(input valid, is_write, cpu_address, write_data, program_counter,
                 output ready);
endinterface

### sv/tpm_out_if.sv
// Interface: decode result channel out of the decoder.
interface tpm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  access_kind;
    logic [23:0] physical_address;
    logic [7:0]  read_data;
    logic [10:0] rom_address;

    modport source(output valid, access_kind, physical_address, read_data, rom_address,
                   input ready);
    modport sink(input valid, access_kind, physical_address, read_data, rom_address,
                 output ready);
endinterface

### sv/tpm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/task_page_map_bus_decoder.sv
// Top level: task page map bus decoder with local space decode.
//
// One processor bus access enters per beat on i_in (is_write, cpu_address,
// write_data, program_counter); one result leaves per beat on o_out
// (access_kind, physical_address, read_data, rom_address).
// Configuration: i_cfg_we writes i_cfg_data into board register i_cfg_index
// (switch settings, keyboard, trap address, trap status).
// An access is taken in S_IDLE, where its map RAM / local RAM read is
// issued; in S_LOOK the read data is there and the result is written
// into the output register. Accesses are handled one at a time: a new beat
// is taken only in S_IDLE, once the previous access has left S_LOOK.
// The result sits in an output register; while the receiver stalls it holds
// there and the decoder finishes the next access and waits with its RAM
// data until the output register frees up.
// After reset the map RAM is cleared, one entry a cycle, all 512 entries;
// no access is accepted then, configuration writes are. Local and FPU RAM
// are not cleared.
module task_page_map_bus_decoder #(
    parameter int SWITCH_DELAY_FETCHES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    tpm_in_if.sink          i_in,
    tpm_out_if.source       o_out
);

    tpm_pkg::t_state r_state, n_state;
    logic [tpm_pkg::MAP_AW-1:0] r_clr_idx, n_clr_idx;

    logic [7:0]  r_act, n_act;
    logic [7:0]  r_pend, n_pend;
    logic [3:0]  r_cd, n_cd;
    logic [15:0] r_lfa, n_lfa;
    logic        r_half, n_half;

    logic [7:0] r_sw, r_kbd, r_trap_a, r_trap_s;

    // in-flight access
    tpm_pkg::t_kind r_kind, n_kind;
    logic [3:0]  r_pa_hi, n_pa_hi;
    logic [11:0] r_offs, n_offs;
    logic [7:0]  r_fix, n_fix;
    logic        r_use_ram, n_use_ram;
    logic [10:0] r_rom, n_rom;

    // output register
    logic           r_o_valid, n_o_valid;
    tpm_pkg::t_kind r_o_kind, n_o_kind;
    logic [23:0]    r_o_pa, n_o_pa;
    logic [7:0]     r_o_data, n_o_data;
    logic [10:0]    r_o_rom, n_o_rom;

    logic                        map_we, map_re;
    logic [tpm_pkg::MAP_AW-1:0]  map_waddr, map_raddr;
    logic [7:0]                  map_wdata, map_rdata;
    logic                        dram_we, dram_re;
    logic [tpm_pkg::DRAM_AW-1:0] dram_addr;
    logic [7:0]                  dram_rdata;

    logic        fire, wr;
    logic [15:0] addr;
    logic [3:0]  cd_t;
    logic [15:0] lfa_t;
    logic [7:0]  act_t;
    logic        mapped;

    tpm_ram #(.WIDTH(8), .DEPTH(tpm_pkg::MAP_BYTES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    tpm_ram #(.WIDTH(8), .DEPTH(tpm_pkg::DRAM_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dram_we),
        .i_waddr (dram_addr),
        .i_wdata (i_in.write_data),
        .i_re    (dram_re),
        .i_raddr (dram_addr),
        .o_rdata (dram_rdata)
    );

    assign i_in.ready        = (r_state == tpm_pkg::S_IDLE);
    assign o_out.valid       = r_o_valid;
    assign o_out.access_kind = r_o_kind;
    assign o_out.physical_address = r_o_pa;
    assign o_out.read_data   = r_o_data;
    assign o_out.rom_address = r_o_rom;

    assign fire = i_in.valid && (r_state == tpm_pkg::S_IDLE);
    assign wr   = i_in.is_write;
    assign addr = i_in.cpu_address;

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_act     = r_act;
        n_pend    = r_pend;
        n_cd      = r_cd;
        n_lfa     = r_lfa;
        n_half    = r_half;
        n_kind    = r_kind;
        n_pa_hi   = r_pa_hi;
        n_offs    = r_offs;
        n_fix     = r_fix;
        n_use_ram = r_use_ram;
        n_rom     = r_rom;
        n_o_valid = r_o_valid;
        n_o_kind  = r_o_kind;
        n_o_pa    = r_o_pa;
        n_o_data  = r_o_data;
        n_o_rom   = r_o_rom;
        map_we    = 1'b0;
        map_re    = 1'b0;
        map_waddr = addr[tpm_pkg::MAP_AW-1:0];
        map_wdata = i_in.write_data;
        dram_we   = 1'b0;
        dram_re   = 1'b0;
        dram_addr = {addr[11], addr[tpm_pkg::LRAM_AW-1:0]};

        // task switch countdown, reads only
        cd_t  = r_cd;
        lfa_t = r_lfa;
        act_t = r_act;
        if (!wr && r_cd != 4'd0) begin
            if (addr == i_in.program_counter && addr != r_lfa) begin
                cd_t  = r_cd - 4'd1;
                lfa_t = addr;
            end
            if (cd_t == 4'd0) begin
                act_t = r_pend;
            end
        end
        mapped    = (act_t[3:0] != 4'd0) || (addr[15:12] != 4'd0);
        map_raddr = {act_t[3:0], addr[15:12], 1'b0};

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            tpm_pkg::S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_idx;
                map_wdata = 8'd0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (&r_clr_idx) begin
                    n_state = tpm_pkg::S_IDLE;
                end
            end
            tpm_pkg::S_IDLE: begin
                if (fire) begin
                    n_state   = tpm_pkg::S_LOOK;
                    n_cd      = cd_t;
                    n_lfa     = lfa_t;
                    n_act     = act_t;
                    n_pa_hi   = act_t[7:4];
                    n_offs    = addr[11:0];
                    n_fix     = 8'd0;
                    n_use_ram = 1'b0;
                    n_rom     = 11'd0;
                    n_kind    = tpm_pkg::KIND_NONE;
                    if (mapped) begin
                        n_kind = tpm_pkg::KIND_EXT;
                        map_re = 1'b1;
                    end else begin
                        priority case (1'b1)
                            addr[11:10] == 2'b00, addr[11:10] == 2'b11: begin
                                n_kind    = tpm_pkg::KIND_LOCAL;
                                n_use_ram = !wr;
                                dram_we   = wr;
                                dram_re   = !wr;
                            end
                            addr[11:9] == 3'b010: begin
                                if (wr) begin
                                    if (addr == tpm_pkg::TASK_REG_ADDR) begin
                                        n_half = 1'b1;
                                        n_cd   = 4'(SWITCH_DELAY_FETCHES);
                                        n_pend = i_in.write_data;
                                    end
                                end else begin
                                    n_kind = tpm_pkg::KIND_LOCAL;
                                    unique case (addr[8:0])
                                        tpm_pkg::BREG_TRAP_ADR: n_fix = r_trap_a;
                                        tpm_pkg::BREG_KEYBOARD: n_fix = r_kbd;
                                        tpm_pkg::BREG_SWITCH:   n_fix = r_sw;
                                        tpm_pkg::BREG_TRAP_STS: n_fix = r_trap_s;
                                        default: n_kind = tpm_pkg::KIND_NONE;
                                    endcase
                                end
                            end
                            addr[11:9] == 3'b011: begin
                                map_we = wr;
                            end
                            default: begin
                                if (!wr) begin
                                    n_kind = tpm_pkg::KIND_ROM;
                                    n_rom  = {r_half, addr[9:0]};
                                end
                            end
                        endcase
                    end
                end
            end
            tpm_pkg::S_LOOK: begin
                if (!r_o_valid || o_out.ready) begin
                    n_state   = tpm_pkg::S_IDLE;
                    n_o_valid = 1'b1;
                    n_o_kind  = r_kind;
                    n_o_pa    = (r_kind == tpm_pkg::KIND_EXT) ?
                                {r_pa_hi, map_rdata, r_offs} : 24'd0;
                    n_o_data  = r_use_ram ? dram_rdata : r_fix;
                    n_o_rom   = r_rom;
                end
            end
            default: n_state = tpm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpm_pkg::S_CLEAR;
            r_clr_idx <= '0;
            r_act     <= 8'd0;
            r_pend    <= 8'd0;
            r_cd      <= 4'd0;
            r_lfa     <= 16'd0;
            r_half    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_act     <= n_act;
            r_pend    <= n_pend;
            r_cd      <= n_cd;
            r_lfa     <= n_lfa;
            r_half    <= n_half;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= tpm_pkg::SWITCH_RESET;
            r_kbd    <= 8'd0;
            r_trap_a <= 8'd0;
            r_trap_s <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (tpm_pkg::t_cfg_index'(i_cfg_index))
                tpm_pkg::CFG_SWITCH:   r_sw     <= i_cfg_data;
                tpm_pkg::CFG_KEYBOARD: r_kbd    <= i_cfg_data;
                tpm_pkg::CFG_TRAP_ADR: r_trap_a <= i_cfg_data;
                tpm_pkg::CFG_TRAP_STS: r_trap_s <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_pa_hi   <= n_pa_hi;
        r_offs    <= n_offs;
        r_fix     <= n_fix;
        r_use_ram <= n_use_ram;
        r_rom     <= n_rom;
        r_o_kind  <= n_o_kind;
        r_o_pa    <= n_o_pa;
        r_o_data  <= n_o_data;
        r_o_rom   <= n_o_rom;
    end

endmodule
